// ----- src/mwto_pkg.sv -----
// ----------------------------------------------------------------------------
// mwto_pkg
// shared widths, parameter defaults and divider request/response types
// ----------------------------------------------------------------------------
`default_nettype none

package mwto_pkg;

  // parameter defaults for the top level
  localparam int unsigned PHASE_BITS_DEF = 16;
  localparam int unsigned DAC_BITS_DEF   = 10;
  localparam int unsigned DAC_SHIFT_DEF  = 6;

  // divider operand widths, fixed by the period and sample field widths
  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned DIVISOR_W  = 16;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- src/mwto_div.sv -----
// ----------------------------------------------------------------------------
// mwto_div
// restoring unsigned divider, one quotient bit per clock
// ----------------------------------------------------------------------------
`default_nettype none

module mwto_div (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  mwto_pkg::div_req_t  req_i,
  output mwto_pkg::div_rsp_t  rsp_o
);
  import mwto_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      cnt_q;
  logic                  done_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVIDEND_W-1:0] quo_q;

  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W+1:0]  diff;
  logic                  ge;

  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~diff[DIVISOR_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (req_i.start) begin
        cnt_q <= CNT_W'(DIVIDEND_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ----- src/multiwave_table_oscillator.sv -----
// ----------------------------------------------------------------------------
// multiwave_table_oscillator
// sine, triangle, square and sawtooth sample generator for a DAC
// ----------------------------------------------------------------------------
// Each accepted item is one tick: the block produces the next sample of one
// period of the selected waveform, shifted into the DAC register layout, and
// flags the last sample of the period. An item with restart set begins the
// period again. The block works on one item at a time and holds in_stall_o
// high from acceptance until the result is registered; the result register
// lets the next item in while the previous sample still waits downstream.
// One 16x16 multiplier and a 32-step bit-serial divider are shared by the
// waves under a small sequencer. Square uses neither; triangle and sawtooth
// multiply the amplitude by the index and then divide by the period; sine
// divides for the phase, then makes five multiplier passes for the
// polynomial and the amplitude scaling.
`default_nettype none

module multiwave_table_oscillator #(
  parameter int unsigned PHASE_BITS = mwto_pkg::PHASE_BITS_DEF,
  parameter int unsigned DAC_BITS   = mwto_pkg::DAC_BITS_DEF,
  parameter int unsigned DAC_SHIFT  = mwto_pkg::DAC_SHIFT_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // tick items
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         restart_i,
  // sample items
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [15:0] sample_word_o,
  output logic        last_of_period_o,
  // register writes
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [15:0] cfg_data_i
);
  import mwto_pkg::*;

  // amplitude bits actually used
  localparam int unsigned AW = (DAC_BITS < 10) ? DAC_BITS : 10;
  // width for comparing the stored phase against the period
  localparam int unsigned CW = (PHASE_BITS > 16) ? PHASE_BITS : 16;

  // sine polynomial coefficients, quarter wave in Q14
  localparam logic [15:0] SIN_K1  = 16'd2320;
  localparam logic [15:0] SIN_K2  = 16'd21024;
  localparam logic [15:0] SIN_K3  = 16'd51472;
  localparam logic [14:0] QUARTER = 15'd16384;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_TRI    = 2'd1,
    WAVE_SQUARE = 2'd2,
    WAVE_SAW    = 2'd3
  } wave_e;

  typedef enum logic [1:0] {
    REG_WAVE   = 2'd0,
    REG_PERIOD = 2'd1,
    REG_AMP    = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_AMP_MUL,
    ST_DIV,
    ST_SQ,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_C4,
    ST_C5,
    ST_DONE
  } state_e;

  state_e               state_q;
  wave_e                wave_q;
  logic [15:0]          period_q;
  logic [9:0]           amp_q;
  logic [PHASE_BITS-1:0] phase_q;

  logic [15:0]          i_q;
  logic                 last_q;
  logic [15:0]          x_q;
  logic                 neg_q;
  logic [15:0]          z2_q;
  logic [15:0]          v_q;
  logic                 out_valid_q;
  logic [15:0]          sample_q;
  logic                 out_last_q;

  logic [31:0]          prod_q;
  logic [15:0]          mul_a;
  logic [15:0]          mul_b;

  div_req_t             div_req;
  div_rsp_t             div_rsp;

  logic                 accept;
  logic [15:0]          n_eff;
  logic [AW-1:0]        a_eff;
  logic [15:0]          a_w;
  logic [15:0]          h_w;
  logic [15:0]          i_eff;
  logic                 last_eff;
  logic                 tri_first;
  logic [16:0]          two_i_minus_n;
  logic [15:0]          prod_sh;
  logic [15:0]          p_w;
  logic [15:0]          x_w;
  logic [33:0]          sin_sum;
  logic [31:0]          shifted_w;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;

  // zero period behaves as a period of one
  assign n_eff = (period_q == 16'd0) ? 16'd1 : period_q;
  assign a_eff = amp_q[AW-1:0];
  assign a_w   = 16'(a_eff);
  assign h_w   = 16'(a_eff >> 1);

  // restart, or a phase left beyond a shortened period, starts at zero
  always_comb begin
    if (restart_i || (CW'(phase_q) >= CW'(n_eff))) begin
      i_eff = '0;
    end else begin
      i_eff = 16'(phase_q);
    end
  end
  assign last_eff = (i_eff == (n_eff - 16'd1));

  assign tri_first     = ({i_q, 1'b0} < {1'b0, n_eff});
  assign two_i_minus_n = {i_q, 1'b0} - {1'b0, n_eff};
  assign prod_sh       = prod_q[29:14];

  // phase folded into the first quadrant
  assign p_w = div_rsp.quotient[15:0];
  assign x_w = p_w[14] ? 16'(QUARTER - {1'b0, p_w[13:0]}) : {2'b00, p_w[13:0]};

  // h*(1 +/- m) with wrap, low bits after the shift by 15
  assign sin_sum = neg_q ? ({3'b000, h_w, 15'b0} - {2'b00, prod_q})
                         : ({3'b000, h_w, 15'b0} + {2'b00, prod_q});

  assign shifted_w = 32'(v_q) << DAC_SHIFT;

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_PREP: begin
        mul_a = a_w;
        mul_b = (wave_q == WAVE_TRI && !tri_first) ? two_i_minus_n[15:0] : i_q;
      end
      ST_SQ: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      ST_C1: begin
        mul_a = SIN_K1;
        mul_b = prod_sh;
      end
      ST_C2: begin
        mul_a = SIN_K2 - prod_sh;
        mul_b = z2_q;
      end
      ST_C3: begin
        mul_a = SIN_K3 - prod_sh;
        mul_b = x_q;
      end
      ST_C4: begin
        mul_a = h_w;
        mul_b = prod_sh;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {16'b0, mul_a} * {16'b0, mul_b};
  end

  // divider request: phase for sine, scaled index for the others
  always_comb begin
    div_req.start    = ((state_q == ST_PREP) && (wave_q == WAVE_SINE)) ||
                       (state_q == ST_AMP_MUL);
    div_req.divisor  = n_eff;
    div_req.dividend = prod_q;
    if (wave_q == WAVE_SINE) begin
      div_req.dividend = {i_q, 16'b0};
    end else if (wave_q == WAVE_TRI) begin
      if (tri_first) begin
        div_req.dividend = {prod_q[30:0], 1'b0};
      end else begin
        // rounds the falling half up
        div_req.dividend = prod_q + 32'(n_eff) - 32'd1;
      end
    end
  end

  mwto_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wave_q      <= WAVE_SINE;
      period_q    <= 16'd100;
      amp_q       <= 10'd1023;
      phase_q     <= '0;
      i_q         <= '0;
      last_q      <= 1'b0;
      x_q         <= '0;
      neg_q       <= 1'b0;
      z2_q        <= '0;
      v_q         <= '0;
      out_valid_q <= 1'b0;
      sample_q    <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_WAVE:   wave_q   <= wave_e'(cfg_data_i[1:0]);
          REG_PERIOD: period_q <= cfg_data_i;
          REG_AMP:    amp_q    <= cfg_data_i[9:0];
          default:    ;
        endcase
      end

      // the completion step refills the result register itself
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            i_q     <= i_eff;
            last_q  <= last_eff;
            phase_q <= last_eff ? '0 : PHASE_BITS'({1'b0, i_eff} + 17'd1);
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          case (wave_q)
            WAVE_SINE:   state_q <= ST_DIV;
            WAVE_SQUARE: begin
              v_q     <= tri_first ? 16'd0 : a_w;
              state_q <= ST_DONE;
            end
            default:     state_q <= ST_AMP_MUL;
          endcase
        end
        ST_AMP_MUL: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            case (wave_q)
              WAVE_SINE: begin
                x_q     <= x_w;
                neg_q   <= p_w[15];
                state_q <= ST_SQ;
              end
              WAVE_TRI: begin
                v_q     <= tri_first ? div_rsp.quotient[15:0]
                                     : (a_w - div_rsp.quotient[15:0]);
                state_q <= ST_DONE;
              end
              default: begin
                v_q     <= div_rsp.quotient[15:0];
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_SQ: begin
          state_q <= ST_C1;
        end
        ST_C1: begin
          z2_q    <= prod_sh;
          state_q <= ST_C2;
        end
        ST_C2: begin
          state_q <= ST_C3;
        end
        ST_C3: begin
          state_q <= ST_C4;
        end
        ST_C4: begin
          state_q <= ST_C5;
        end
        ST_C5: begin
          v_q     <= sin_sum[30:15];
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // wait for the result register to free up
          if (!out_valid_q || !out_stall_i) begin
            sample_q    <= shifted_w[15:0];
            out_last_q  <= last_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sample_word_o    = sample_q;
  assign last_of_period_o = out_last_q;

  // the block goes busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("not busy after item accepted");

  // divider results only arrive while the sequencer waits for them
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider done outside wait state");

  // a new sample only comes from the completion step
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("sample issued outside completion step");

endmodule

`default_nettype wire
